[hw/rtl/task_table_scheduler_assert.svh]
// Assertion macros for the task table scheduler port checker.
`ifndef TASK_TABLE_SCHEDULER_ASSERT_SVH
`define TASK_TABLE_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tts_pkg.sv]
// Shared types and constants of the task table scheduler.
package tts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int PRIO_W        = 8;
  localparam int ID_W          = 4;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE      = 2'd0,
    CMD_CREATE_PRIO = 2'd1,
    CMD_SCHEDULE    = 2'd2,
    CMD_QUERY       = 2'd3
  } cmd_t;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PRIO_W-1:0] priority_req;
  } req_item_t;

  typedef struct packed {
    logic [ID_W-1:0]     task_id;
    logic [STATUS_W-1:0] status;
  } rsp_item_t;

  // Flags from the shared step unit back to the sequencer.
  typedef struct packed {
    logic at_end;  // index plus one reaches the allocated count
    logic hit;     // other slot with priority at or below the reference
  } step_flags_t;

endpackage

[hw/rtl/task_table_scheduler.sv]
// Task table scheduler top level: register port and command sequencer.
//
// Requests (req_valid/req_ready/req) carry a command and a priority; each
// accepted item yields exactly one response item on rsp_valid/rsp_ready/rsp.
// Create, query and round-robin schedule finish in the accepting cycle; the
// result is registered and, barring a receiver stall, a new item can be taken
// every cycle. A priority-mode schedule reads the current slot's priority,
// then scans the table one slot per cycle through the single memory read
// port; req_ready stays low until the scan ends. Register sched_mode (byte
// address 0) picks round robin (0) or priority scan (1); the user ensures it
// is written only while the block is idle, which the block does not enforce.
// Reset empties the table, sets the current task to 0 and selects round
// robin; no clearing pass is needed since every allocated slot is written
// when it is created. When the receiver stalls, the block still takes one
// more item and parks its response in a pending register until the output
// register drains; further items wait.
module task_table_scheduler #(
  parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_ready,
  input  tts_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output tts_pkg::rsp_item_t rsp
);
  import tts_pkg::*;

  localparam logic REG_SCHED_MODE = 1'b0;

  logic sched_mode;
  logic cfg_write;

  // Register port: zero wait states, the register word sits at address 0.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode <= 1'b0;
    end else if (cfg_write && (paddr[2] == REG_SCHED_MODE)) begin
      sched_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SCHED_MODE) begin
      prdata[0] = sched_mode;
    end
  end

  tts_core #(
    .MAX_TASKS (MAX_TASKS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .sched_mode (sched_mode),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule

[hw/rtl/tts_prio_ram.sv]
// Priority table memory with one write port and one registered read port.
module tts_prio_ram #(
  parameter int DEPTH  = tts_pkg::MAX_TASKS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [tts_pkg::PRIO_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [tts_pkg::PRIO_W-1:0] rdata
);
  import tts_pkg::*;

  logic [PRIO_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/tts_step_unit.sv]
// Shared index increment, end-of-table compare and priority compare.
module tts_step_unit #(
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic [IDX_W-1:0]           idx,
  input  logic [IDX_W-1:0]           self_idx,
  input  logic [CNT_W-1:0]           limit,
  input  logic [tts_pkg::PRIO_W-1:0] prio_a,
  input  logic [tts_pkg::PRIO_W-1:0] prio_b,
  output logic [IDX_W-1:0]           idx_inc,
  output tts_pkg::step_flags_t       flags
);
  import tts_pkg::*;

  logic [CNT_W:0] sum;

  // One increment serves both the round-robin step and the scan step.
  assign sum     = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
  assign idx_inc = sum[IDX_W-1:0];

  assign flags.at_end = (sum >= (CNT_W+1)'(limit));
  assign flags.hit    = (idx != self_idx) && (prio_a <= prio_b);

endmodule

[hw/rtl/tts_core.sv]
// Command sequencer: task table state, priority scan and response register.
module tts_core #(
  parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF,
  parameter int IDX_W     = $clog2(MAX_TASKS),
  parameter int CNT_W     = $clog2(MAX_TASKS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sched_mode,
  input  logic               req_valid,
  output logic               req_ready,
  input  tts_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output tts_pkg::rsp_item_t rsp
);
  import tts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CUR  = 4'b0010,
    S_SCAN = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  task_count, task_count_next;
  logic [IDX_W-1:0]  current_task, current_task_next;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic [PRIO_W-1:0] cur_prio, cur_prio_next;
  logic              rsp_valid_next;
  rsp_item_t         rsp_next;
  rsp_item_t         pend, pend_next;

  // Memory port signals.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [PRIO_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [PRIO_W-1:0] ram_rdata;

  // Shared step unit signals.
  logic [IDX_W-1:0]  step_idx;
  logic [IDX_W-1:0]  step_inc;
  step_flags_t       step_flags;

  // Result of the current item, when one is ready this cycle.
  logic              res_ready;
  logic [IDX_W-1:0]  res_idx;
  status_t           res_status;
  logic [IDX_W+3:0]  res_ext;

  logic              accept;
  logic              table_full;

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign table_full = (task_count == CNT_W'(MAX_TASKS));
  assign step_idx   = (state == S_SCAN) ? scan_idx : current_task;
  assign res_ext    = {4'b0000, res_idx};

  tts_prio_ram #(
    .DEPTH  (MAX_TASKS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tts_step_unit #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_step (
    .idx      (step_idx),
    .self_idx (current_task),
    .limit    (task_count),
    .prio_a   (ram_rdata),
    .prio_b   (cur_prio),
    .idx_inc  (step_inc),
    .flags    (step_flags)
  );

  // Sequencer next-state logic, response register and pending slot.
  always_comb begin
    state_next        = state;
    task_count_next   = task_count;
    current_task_next = current_task;
    scan_idx_next     = scan_idx;
    cur_prio_next     = cur_prio;
    ram_we            = 1'b0;
    ram_waddr         = task_count[IDX_W-1:0];
    ram_wdata         = '0;
    ram_re            = 1'b0;
    ram_raddr         = current_task;
    res_ready         = 1'b0;
    res_idx           = current_task;
    res_status        = ST_OK;
    rsp_valid_next    = rsp_valid;
    rsp_next          = rsp;
    pend_next         = pend;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.command)
            CMD_CREATE, CMD_CREATE_PRIO: begin
              res_ready = 1'b1;
              if (table_full) begin
                res_idx    = '0;
                res_status = ST_FULL;
              end else begin
                // A plain create stores zero so every allocated slot is written.
                res_idx         = task_count[IDX_W-1:0];
                ram_we          = 1'b1;
                ram_wdata       = (req.command == CMD_CREATE_PRIO) ? req.priority_req : '0;
                task_count_next = task_count + CNT_W'(1);
              end
            end
            CMD_SCHEDULE: begin
              if (task_count == '0) begin
                res_ready  = 1'b1;
                res_status = ST_EMPTY;
              end else if (!sched_mode) begin
                res_ready         = 1'b1;
                current_task_next = step_flags.at_end ? '0 : step_inc;
                res_idx           = current_task_next;
              end else begin
                // Fetch the current slot's priority first.
                ram_re     = 1'b1;
                ram_raddr  = current_task;
                state_next = S_CUR;
              end
            end
            default: begin
              res_ready = 1'b1;
            end
          endcase
        end
      end
      S_CUR: begin
        cur_prio_next = ram_rdata;
        scan_idx_next = '0;
        ram_re        = 1'b1;
        ram_raddr     = '0;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        // Read data holds the priority of scan_idx.
        if (step_flags.hit) begin
          res_ready         = 1'b1;
          current_task_next = scan_idx;
          res_idx           = scan_idx;
        end else if (step_flags.at_end) begin
          res_ready = 1'b1;
        end else begin
          scan_idx_next = step_inc;
          ram_re        = 1'b1;
          ram_raddr     = step_inc;
        end
      end
      S_HOLD: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Response register and pending slot when the receiver stalls.
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
    if (state == S_HOLD) begin
      if (rsp_ready) begin
        rsp_valid_next = 1'b1;
        rsp_next       = pend;
      end
    end else if (res_ready) begin
      if (!rsp_valid || rsp_ready) begin
        rsp_valid_next   = 1'b1;
        rsp_next.task_id = res_ext[3:0];
        rsp_next.status  = res_status;
        state_next       = S_IDLE;
      end else begin
        pend_next.task_id = res_ext[3:0];
        pend_next.status  = res_status;
        state_next        = S_HOLD;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      task_count   <= '0;
      current_task <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      task_count   <= task_count_next;
      current_task <= current_task_next;
      rsp_valid    <= rsp_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    cur_prio <= cur_prio_next;
    rsp      <= rsp_next;
    pend     <= pend_next;
  end

endmodule

[hw/rtl/tts_checker.sv]
// Port-level assertions for the task table scheduler and their binding.
`include "task_table_scheduler_assert.svh"

module tts_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input tts_pkg::req_item_t req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input tts_pkg::rsp_item_t rsp
);
  import tts_pkg::*;

  // A stalled response keeps its payload.
  `TTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

  // A full table reports slot zero.
  `TTS_ASSERT_NOW(a_full_id, rsp_valid && (rsp.status == ST_FULL), rsp.task_id == '0, "full status with nonzero id")

  // Only defined status codes are sent.
  `TTS_ASSERT_NOW(a_status_code, rsp_valid, (rsp.status == ST_OK) || (rsp.status == ST_FULL) || (rsp.status == ST_EMPTY), "undefined status code")

  // No response right after reset.
  `TTS_ASSERT_NOW(a_reset_quiet, $past(rst), !rsp_valid, "response valid right after reset")

endmodule

bind task_table_scheduler tts_checker u_tts_checker (.*);

[dv/task_table_scheduler_checker.sv]
// Checker for the task table scheduler: tracks the table, predicts each response and compares.
`timescale 1ns / 100ps

module task_table_scheduler_checker #(
  parameter logic [2:0] SCHED_MODE_ADDR = 3'd0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               req_valid,
  input  logic               req_ready,
  input  tts_pkg::req_item_t req,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  tts_pkg::rsp_item_t rsp,
  output int                 mismatches,
  output int                 expected_left
);
  import tts_pkg::*;

  // Shadow copy of the scheduler state.
  logic              prio_mode;
  logic [4:0]        slot_count;
  logic [ID_W-1:0]   cur_slot;
  logic [PRIO_W-1:0] slot_prio [MAX_TASKS_DEF];

  rsp_item_t predicted_rsp_q [$];
  rsp_item_t want;
  int        errors = 0;

  // Applies one command to the shadow table and returns the response it must produce.
  function automatic rsp_item_t apply_command(req_item_t item);
    rsp_item_t         result;
    logic [PRIO_W-1:0] cur_prio;
    logic              found;
    result.task_id = '0;
    result.status  = ST_OK;
    case (cmd_t'(item.command))
      CMD_CREATE, CMD_CREATE_PRIO: begin
        if (slot_count >= MAX_TASKS_DEF) begin
          result.status = ST_FULL;
        end else begin
          // A plain create keeps the slot's priority, which is still zero from reset.
          result.task_id = slot_count[ID_W-1:0];
          if (cmd_t'(item.command) == CMD_CREATE_PRIO)
            slot_prio[slot_count[ID_W-1:0]] = item.priority_req;
          slot_count = slot_count + 5'd1;
        end
      end
      CMD_SCHEDULE: begin
        if (slot_count == 5'd0) begin
          result.status = ST_EMPTY;
        end else if (!prio_mode) begin
          // Round robin wraps at the number of allocated slots.
          if ({1'b0, cur_slot} + 5'd1 >= slot_count)
            cur_slot = '0;
          else
            cur_slot = cur_slot + 1'b1;
        end else begin
          // First other slot at or below the current priority; none found keeps the current one.
          cur_prio = slot_prio[cur_slot];
          found    = 1'b0;
          for (int i = 0; i < MAX_TASKS_DEF; i++) begin
            if (!found && i < slot_count && i != cur_slot && slot_prio[i] <= cur_prio) begin
              cur_slot = i[ID_W-1:0];
              found    = 1'b1;
            end
          end
        end
        result.task_id = cur_slot;
      end
      default: begin
        result.task_id = cur_slot;
      end
    endcase
    return result;
  endfunction

  // Watch the register port and both channels at every edge.
  always @(posedge clk) begin
    if (rst) begin
      prio_mode  = 1'b0;
      slot_count = '0;
      cur_slot   = '0;
      foreach (slot_prio[i]) slot_prio[i] = '0;
      predicted_rsp_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == SCHED_MODE_ADDR)
        prio_mode = pwdata[0];

      if (rsp_valid && rsp_ready) begin
        if (predicted_rsp_q.size() == 0) begin
          errors++;
          $error("unexpected response: task_id %0d, status %0d", rsp.task_id, rsp.status);
        end else begin
          want = predicted_rsp_q.pop_front();
          if (rsp.task_id !== want.task_id) begin
            errors++;
            $error("task_id mismatch: expected %0d, actual %0d", want.task_id, rsp.task_id);
          end
          if (rsp.status !== want.status) begin
            errors++;
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
          end
        end
      end

      if (req_valid && req_ready)
        predicted_rsp_q.push_back(apply_command(req));
    end
    mismatches    <= errors;
    expected_left <= predicted_rsp_q.size();
  end

endmodule

[dv/task_table_scheduler_tb.sv]
// Top of the task table scheduler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module task_table_scheduler_tb;
  import tts_pkg::*;

  localparam logic [2:0] SCHED_MODE_ADDR = 3'd0;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 230;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid;
  logic        req_ready;
  req_item_t   req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_item_t   rsp;

  int mismatches;
  int expected_left;
  int stall_style = 0;
  int stall_left  = 0;
  int idle_cycles = 0;
  int gap_max     = 0;
  int burst_left  = 1;

  task_table_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  task_table_scheduler_checker #(
    .SCHED_MODE_ADDR (SCHED_MODE_ADDR)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Response backpressure: always ready, random stalls, or stretches of stalls.
  always @(posedge clk) begin
    case (stall_style)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= ($urandom_range(0, 2) != 0);
      default: begin
        if (stall_left > 0) begin
          rsp_ready  <= 1'b0;
          stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
          rsp_ready  <= 1'b0;
          stall_left <= $urandom_range(1, 12);
        end else begin
          rsp_ready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("task_table_scheduler_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one item and holds it until accepted; ends a burst with a random gap.
  task automatic send_item(cmd_t cmd, logic [PRIO_W-1:0] prio);
    req_item_t item;
    item.command      = cmd;
    item.priority_req = prio;
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (gap_max > 0) begin
      burst_left--;
      if (burst_left <= 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end
    end
  endtask

  // Stops sending and waits until every predicted response has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  // Register write with setup and access cycles; upper data bits are random.
  task automatic write_sched_mode(logic mode);
    logic [31:0] data;
    data    = $urandom();
    data[0] = mode;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SCHED_MODE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int                pick;
    cmd_t              cmd;
    logic [PRIO_W-1:0] prio;

    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    req_valid <= 1'b0;
    req       <= '0;
    rsp_ready <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty table: query and round-robin schedule.
    send_item(CMD_QUERY, PRIO_W'($urandom_range(0, 255)));
    send_item(CMD_SCHEDULE, PRIO_W'($urandom_range(0, 255)));

    // Priority mode: empty schedule, a lone task, then scans among equal and lower priorities.
    wait_drained();
    write_sched_mode(1'b1);
    send_item(CMD_SCHEDULE, PRIO_W'($urandom_range(0, 255)));
    send_item(CMD_CREATE_PRIO, 8'hFF);
    send_item(CMD_SCHEDULE, PRIO_W'($urandom_range(0, 255)));
    send_item(CMD_CREATE, 8'hFF);
    send_item(CMD_CREATE_PRIO, 8'h00);
    send_item(CMD_SCHEDULE, 8'h00);
    send_item(CMD_SCHEDULE, 8'hFF);
    send_item(CMD_SCHEDULE, 8'h00);
    send_item(CMD_CREATE_PRIO, 8'hAA);
    send_item(CMD_QUERY, 8'h55);

    // Back to round robin, walking through the wrap.
    wait_drained();
    write_sched_mode(1'b0);
    send_item(CMD_SCHEDULE, 8'hAA);
    send_item(CMD_SCHEDULE, 8'h55);
    send_item(CMD_SCHEDULE, PRIO_W'($urandom_range(0, 255)));
    send_item(CMD_CREATE_PRIO, 8'h55);
    send_item(CMD_QUERY, PRIO_W'($urandom_range(0, 255)));

    // Random phases, each with its own mode, backpressure and sender gaps.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      if (phase == 0)
        write_sched_mode(1'b1);
      else if (phase == 1)
        write_sched_mode(1'b0);
      else
        write_sched_mode($urandom_range(0, 1) == 1);
      stall_style <= (phase == 0) ? 0 : $urandom_range(0, 2);
      gap_max    = (phase == 0) ? 0 : $urandom_range(0, 2) * 4;
      burst_left = $urandom_range(1, 10);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)
          cmd = CMD_CREATE;
        else if (pick < 35)
          cmd = CMD_CREATE_PRIO;
        else if (pick < 80)
          cmd = CMD_SCHEDULE;
        else
          cmd = CMD_QUERY;
        // Favor a few repeated priorities so that ties and scan misses are common.
        case ($urandom_range(0, 3))
          0: prio = 8'h00;
          1: prio = 8'hFF;
          2: prio = PRIO_W'($urandom_range(0, 3));
          default: prio = PRIO_W'($urandom_range(0, 255));
        endcase
        send_item(cmd, prio);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("task_table_scheduler_tb passed");
    else
      $display("task_table_scheduler_tb failed");
    $finish;
  end

endmodule
